FILE: rtl/isst_pkg.sv
// Shared types, command codes and read-tree sizing for the indexed sequence store.
// No dependencies; every other file imports this package.
package isst_pkg;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 9;

	typedef logic [WORD_W-1:0] word_t;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_DELETE,
		CELL_INSERT,
		CELL_SWAP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    data;  // new word for append/insert, word read at position b for swap
		word_t    alt;   // word read at position a, written to position b on swap
	} cell_ctl_t;

	// Read tree: radix-16 OR reduction, one register level per stage
	localparam int TREE_RADIX_LOG = 4;
	localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

	function automatic int tree_width(int n, int lvl);
		int w;
		w = n;
		for (int k = 0; k < lvl; k++) begin
			w = (w + TREE_RADIX - 1) >> TREE_RADIX_LOG;
		end
		return w;
	endfunction

	function automatic int tree_levels(int n);
		int w;
		int l;
		w = n;
		l = 0;
		while (w > 1 || l == 0) begin
			w = (w + TREE_RADIX - 1) >> TREE_RADIX_LOG;
			l++;
		end
		return l;
	endfunction

endpackage

FILE: rtl/isst_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on isst_pkg for field widths.
interface isst_cmd_if;
	import isst_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [POS_W-1:0]         position_a;
	logic [POS_W-1:0]         position_b;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, kind, position_a, position_b, value, input ready);
	modport sink   (input valid, kind, position_a, position_b, value, output ready);
endinterface

interface isst_rsp_if;
	import isst_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_value;
	logic [STATUS_W-1:0]      status;
	logic [LEN_W-1:0]         length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink   (input valid, read_value, status, length, output ready);
endinterface

FILE: rtl/indexed_sequence_store.sv
// Top level of the indexed sequence store: command decode, cell chain, read trees,
// result register. Depends on isst_pkg, isst_if, isst_cell and isst_rdtree.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    kind, position_a, position_b, value
//   rsp      out  valid/ready    read_value, status, length
//
// Append, delete, insert, failed commands and unknown kinds end in the accepting edge:
// cells shift or load as needed, so one item per cycle is sustained while rsp drains.
// Get and swap read through the registered select trees: the block waits in ST_READ while
// the trees settle, loads the result in ST_FINISH and only then returns to ST_IDLE, so it
// takes no new command until the read is through.
// Reset clears the entry count and control; cell words stay undefined until written.
// A stalled result register holds its item; a new command is taken once it drains.
module indexed_sequence_store import isst_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	isst_cmd_if.sink   cmd,
	isst_rsp_if.source rsp
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int XW  = (CW > POS_W) ? CW : POS_W;
	localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
	localparam int L   = tree_levels(DEPTH);
	localparam int TCW = $clog2(L + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_READ   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [TCW-1:0]       wait_q;
	logic [CW-1:0]        pa_q;
	logic [CW-1:0]        pb_q;
	logic                 swap_q;
	logic                 out_valid_q;
	word_t                read_value_q;
	logic [STATUS_W-1:0]  status_q;
	logic [LEN_W-1:0]     length_q;

	logic                 out_free;
	logic                 accept;
	logic                 finish_go;
	logic [XW-1:0]        pa_x;
	logic [XW-1:0]        pb_x;
	logic [XW-1:0]        cnt_x;
	logic                 full;
	logic                 pa_bad;
	logic                 pb_bad;
	logic                 need_read;
	cell_op_t             dec_op;
	logic [STATUS_W-1:0]  dec_status;
	logic [CW-1:0]        dec_count;
	logic [CW-1:0]        dec_pos;
	logic [CW-1:0]        len_src;
	logic [LW-1:0]        len_ext;
	cell_ctl_t            ctl;
	logic [CW-1:0]        cell_pos_a;
	word_t                cell_val [DEPTH];
	word_t                rd_a;
	word_t                rd_b;

	// Handshake
	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	// Range and capacity checks
	assign pa_x   = XW'(cmd.position_a);
	assign pb_x   = XW'(cmd.position_b);
	assign cnt_x  = XW'(count_q);
	assign full   = (count_q == CW'(DEPTH));
	assign pa_bad = (pa_x >= cnt_x);
	assign pb_bad = (pb_x >= cnt_x);

	// Decode the command
	always_comb begin
		dec_op     = CELL_HOLD;
		dec_status = STATUS_OK;
		dec_count  = count_q;
		dec_pos    = CW'(pa_x);
		need_read  = 1'b0;
		unique case (cmd.kind)
			KIND_APPEND: begin
				if (full) begin
					dec_status = STATUS_FULL;
				end else begin
					dec_op    = CELL_APPEND;
					dec_count = count_q + CW'(1);
				end
			end
			KIND_GET: begin
				if (pa_bad) dec_status = STATUS_RANGE;
				else need_read = 1'b1;
			end
			KIND_DELETE: begin
				if (pa_bad) begin
					dec_status = STATUS_RANGE;
				end else begin
					dec_op    = CELL_DELETE;
					dec_count = count_q - CW'(1);
				end
			end
			KIND_INSERT: begin
				if (full) begin
					dec_status = STATUS_FULL;
				end else begin
					dec_op    = CELL_INSERT;
					dec_count = count_q + CW'(1);
					if (pa_bad) dec_pos = count_q;
				end
			end
			KIND_SWAP: begin
				if (pa_bad || pb_bad) dec_status = STATUS_RANGE;
				else need_read = 1'b1;
			end
			default: ;
		endcase
	end

	// Drive the cell chain
	always_comb begin
		ctl.alt = rd_a;
		if (accept) begin
			ctl.op     = dec_op;
			ctl.data   = word_t'(cmd.value);
			cell_pos_a = dec_pos;
		end else begin
			ctl.op     = (finish_go && swap_q) ? CELL_SWAP : CELL_HOLD;
			ctl.data   = rd_b;
			cell_pos_a = pa_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_body_l
			assign left_w = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body_r
			assign right_w = cell_val[i+1];
		end
		isst_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos_a (cell_pos_a),
			.pos_b (pb_q),
			.count (count_q),
			.left  (left_w),
			.right (right_w),
			.value (cell_val[i])
		);
	end

	// Read both swap positions in parallel
	isst_rdtree #(.N(DEPTH), .CW(CW)) u_rd_a (
		.clk   (clk),
		.sel   (pa_q),
		.vals  (cell_val),
		.rdata (rd_a)
	);

	isst_rdtree #(.N(DEPTH), .CW(CW)) u_rd_b (
		.clk   (clk),
		.sel   (pb_q),
		.vals  (cell_val),
		.rdata (rd_b)
	);

	// Control: state, count, read wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= dec_count;
						if (need_read) begin
							state_q <= ST_READ;
							wait_q  <= TCW'(L - 1);
						end
					end
				end
				ST_READ: begin
					if (wait_q == '0) state_q <= ST_FINISH;
					else wait_q <= wait_q - TCW'(1);
				end
				ST_FINISH: begin
					if (finish_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the read positions of a get or swap
	always_ff @(posedge clk) begin
		if (accept && need_read) begin
			pa_q   <= CW'(pa_x);
			pb_q   <= CW'(pb_x);
			swap_q <= (cmd.kind == KIND_SWAP);
		end
	end

	// Result register
	assign len_src = accept ? dec_count : count_q;
	assign len_ext = LW'(len_src);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !need_read) || finish_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !need_read) begin
			read_value_q <= '0;
			status_q     <= dec_status;
			length_q     <= len_ext[LEN_W-1:0];
		end else if (finish_go) begin
			read_value_q <= swap_q ? '0 : rd_a;
			status_q     <= STATUS_OK;
			length_q     <= len_ext[LEN_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = $signed(read_value_q);
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == KIND_APPEND && !full) |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow the store");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == KIND_DELETE && !pa_bad) |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the store");

	a_finish_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (pa_q < count_q && (!swap_q || pb_q < count_q)))
		else $error("read position out of range at finish");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_FULL) |-> (len_ext == LW'(DEPTH) ||
		rsp.length == LEN_W'(DEPTH)))
		else $error("full status with short length");

endmodule

FILE: rtl/isst_cell.sv
// One storage cell of the chain: holds a single word and takes its neighbor's word
// on shifts. Depends on isst_pkg.
module isst_cell import isst_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] pos_a,
	input  logic [CW-1:0] pos_b,
	input  logic [CW-1:0] count,
	input  word_t         left,
	input  word_t         right,
	output word_t         value
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	word_t value_q;

	// Update own word from the broadcast command and the neighbors
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_APPEND: begin
				if (IDX_C == count) value_q <= ctl.data;
			end
			CELL_DELETE: begin
				if (IDX_C >= pos_a && IDX_C < count - CW'(1)) value_q <= right;
			end
			CELL_INSERT: begin
				if (IDX_C == pos_a) value_q <= ctl.data;
				else if (IDX_C > pos_a && IDX_C <= count) value_q <= left;
			end
			CELL_SWAP: begin
				if (IDX_C == pos_a) value_q <= ctl.data;
				else if (IDX_C == pos_b) value_q <= ctl.alt;
			end
			default: ;
		endcase
	end

	assign value = value_q;

endmodule

FILE: rtl/isst_rdtree.sv
// Registered radix-16 select tree that reads the word of one cell by position.
// Each tree level is registered. Depends on isst_pkg.
module isst_rdtree import isst_pkg::*; #(
	parameter int N  = 256,
	parameter int CW = 9
) (
	input  logic          clk,
	input  logic [CW-1:0] sel,
	input  word_t         vals [N],
	output word_t         rdata
);

	localparam int L = tree_levels(N);

	word_t leaf [N];
	word_t node_q [1:L][N];

	// Mask every word but the selected one
	always_comb begin
		for (int j = 0; j < N; j++) begin
			leaf[j] = (sel == CW'(j)) ? vals[j] : '0;
		end
	end

	// Reduce sixteen nodes into one per level
	for (genvar g = 1; g <= L; g++) begin : g_lvl
		localparam int NW = tree_width(N, g);
		localparam int PW = tree_width(N, g - 1);
		for (genvar k = 0; k < NW; k++) begin : g_node
			if (g == 1) begin : g_first
				always_ff @(posedge clk) begin
					word_t acc;
					acc = '0;
					for (int j = 0; j < TREE_RADIX; j++) begin
						if (k * TREE_RADIX + j < PW) acc = acc | leaf[k * TREE_RADIX + j];
					end
					node_q[g][k] <= acc;
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					word_t acc;
					acc = '0;
					for (int j = 0; j < TREE_RADIX; j++) begin
						if (k * TREE_RADIX + j < PW) acc = acc | node_q[g-1][k * TREE_RADIX + j];
					end
					node_q[g][k] <= acc;
				end
			end
		end
	end

	assign rdata = node_q[L][0];

endmodule

FILE: tb/sv/isst_result_check.sv
`timescale 1ns / 100ps
// Result checker for the indexed sequence store: keeps its own copy of the stored words,
// works out each result from accepted command items and compares it. Depends on isst_pkg, isst_if.
module isst_result_check import isst_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	isst_cmd_if  cmd,
	isst_rsp_if  rsp,
	output int   mismatch_count,
	output int   results_owed
);

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [STATUS_W-1:0]      status;
		logic [LEN_W-1:0]         length;
	} store_result_t;

	word_t         contents [DEPTH];
	int            stored_count = 0;
	store_result_t owed_results [$];

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
	end

	// Apply one command to the mirrored store and return the result it reports
	function automatic store_result_t apply_command(input logic [KIND_W-1:0] op,
			input logic [POS_W-1:0] pos_a, input logic [POS_W-1:0] pos_b, input word_t word);
		store_result_t res;
		word_t         spare;
		int            slot;
		res.read_value = '0;
		res.status     = STATUS_OK;
		case (op)
			KIND_APPEND: begin
				if (stored_count >= DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					contents[stored_count] = word;
					stored_count++;
				end
			end
			KIND_GET: begin
				if (pos_a >= stored_count) begin
					res.status = STATUS_RANGE;
				end else begin
					res.read_value = contents[pos_a];
				end
			end
			KIND_DELETE: begin
				if (pos_a >= stored_count) begin
					res.status = STATUS_RANGE;
				end else begin
					// close the gap behind the removed word
					for (int i = pos_a; i + 1 < stored_count; i++) begin
						contents[i] = contents[i + 1];
					end
					stored_count--;
				end
			end
			KIND_INSERT: begin
				if (stored_count >= DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					// a position at or past the end appends
					slot = (pos_a < stored_count) ? int'(pos_a) : stored_count;
					for (int i = stored_count; i > slot; i--) begin
						contents[i] = contents[i - 1];
					end
					contents[slot] = word;
					stored_count++;
				end
			end
			KIND_SWAP: begin
				if (pos_a >= stored_count || pos_b >= stored_count) begin
					res.status = STATUS_RANGE;
				end else begin
					spare           = contents[pos_a];
					contents[pos_a] = contents[pos_b];
					contents[pos_b] = spare;
				end
			end
			default: begin
				// unknown kinds leave the store alone
			end
		endcase
		res.length = LEN_W'(stored_count);
		return res;
	endfunction

	// Match result items against the oldest owed result, then record new commands
	always @(posedge clk) begin : watch_channels
		store_result_t want;
		logic          took_cmd;
		logic          took_rsp;
		took_cmd = arst_n && cmd.valid && cmd.ready;
		took_rsp = arst_n && rsp.valid && rsp.ready;
		if (took_rsp) begin
			if (owed_results.size() == 0) begin
				$error("result item with no command waiting: read_value %0d status %0d length %0d",
					rsp.read_value, rsp.status, rsp.length);
				mismatch_count++;
			end else begin
				want = owed_results.pop_front();
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d", want.read_value, rsp.read_value);
					mismatch_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.length !== want.length) begin
					$error("length: expected %0d, actual %0d", want.length, rsp.length);
					mismatch_count++;
				end
			end
		end
		if (took_cmd) begin
			owed_results.push_back(apply_command(cmd.kind, cmd.position_a, cmd.position_b,
				cmd.value));
		end
		results_owed <= owed_results.size();
	end

endmodule

FILE: tb/sv/indexed_sequence_store_tb.sv
`timescale 1ns / 100ps
// Testbench top for the indexed sequence store: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on isst_pkg, isst_if, the block and isst_result_check.
module indexed_sequence_store_tb import isst_pkg::*;;

	localparam int DEPTH         = 256;
	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_ITEMS  = 1325;
	localparam int IDLE_PERCENT  = 18;
	localparam int STEADY_FIRST  = 650;
	localparam int STEADY_LAST   = 850;
	localparam int HOLD_AT_ITEM  = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_AT_ITEM = 1000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RUN_LIMIT_NS  = 4_000_000;

	localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
	localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 3'd7;
	localparam logic [POS_W-1:0]  POS_LAST          = '1;
	localparam word_t WORD_MAX  = 32'h7FFF_FFFF;
	localparam word_t WORD_MIN  = 32'h8000_0000;
	localparam word_t WORD_ONES = '1;
	localparam word_t CORNER_WORDS [5] = '{32'h0, 32'h1, WORD_ONES, WORD_MAX, WORD_MIN};

	logic clk           = 1'b0;
	logic arst_n        = 1'b0;
	logic receiver_hold = 1'b0;
	logic steady_window = 1'b0;
	int   items_sent    = 0;
	int   fill_level    = 0;
	int   mismatch_count;
	int   results_owed;

	isst_cmd_if cmd_ch ();
	isst_rsp_if rsp_ch ();

	indexed_sequence_store #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	isst_result_check #(.DEPTH(DEPTH)) store_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stop a hung run
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("indexed_sequence_store verification failed");
		$finish;
	end

	// Drive result ready: random stalls, a quiet stretch and one long hold-off
	initial begin : result_ready
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n || receiver_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (steady_window) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Hold off results long enough for the block to stall its command input
	initial begin : result_hold
		wait (items_sent >= HOLD_AT_ITEM);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// Offer one command item and wait for it to be taken
	task automatic send_command(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos_a,
			input logic [POS_W-1:0] pos_b, input word_t word);
		if (items_sent < STEADY_FIRST || items_sent >= STEADY_LAST) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= op;
		cmd_ch.position_a <= pos_a;
		cmd_ch.position_b <= pos_b;
		cmd_ch.value      <= word;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		// track the entry count so positions can be aimed inside the store
		if ((op == KIND_APPEND || op == KIND_INSERT) && fill_level < DEPTH) begin
			fill_level++;
		end else if (op == KIND_DELETE && pos_a < fill_level) begin
			fill_level--;
		end
		items_sent++;
		steady_window <= (items_sent >= STEADY_FIRST && items_sent < STEADY_LAST);
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic wait_for_drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// Mostly a live position, sometimes one just past the end or anywhere
	function automatic logic [POS_W-1:0] pick_position(input int count);
		int roll;
		roll = $urandom_range(99);
		if (count == 0 || roll < 8) begin
			return POS_W'($urandom_range(255));
		end
		if (roll < 14) begin
			return (count > 255) ? POS_LAST : POS_W'(count);
		end
		return POS_W'($urandom_range(count - 1));
	endfunction

	initial begin : stimulus
		logic [KIND_W-1:0] op;
		word_t             word;
		int                roll;
		bit                growing;
		growing = 1'b1;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.kind       <= KIND_APPEND;
		cmd_ch.position_a <= '0;
		cmd_ch.position_b <= '0;
		cmd_ch.value      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: every position is out of range
		send_command(KIND_GET, '0, '0, '0);
		send_command(KIND_DELETE, '0, '0, '0);
		send_command(KIND_SWAP, '0, '0, '0);
		// Insert into an empty store appends; deleting the only entry empties it
		send_command(KIND_INSERT, 8'd5, '0, WORD_MAX);
		send_command(KIND_DELETE, '0, '0, '0);
		// Build six entries through front, middle and past-the-end inserts
		send_command(KIND_INSERT, '0, '0, WORD_MAX);
		send_command(KIND_APPEND, '0, '0, WORD_MIN);
		send_command(KIND_APPEND, '0, '0, WORD_ONES);
		send_command(KIND_INSERT, '0, '0, '0);
		send_command(KIND_INSERT, 8'd2, '0, 32'h5A5A_5A5A);
		send_command(KIND_INSERT, POS_LAST, '0, 32'hA5A5_A5A5);
		// Swap in both orders, on equal positions, and out of range on either side
		send_command(KIND_SWAP, '0, 8'd5, '0);
		send_command(KIND_SWAP, 8'd5, '0, '0);
		send_command(KIND_SWAP, 8'd2, 8'd2, '0);
		send_command(KIND_SWAP, 8'd1, POS_LAST, '0);
		send_command(KIND_SWAP, POS_LAST, 8'd1, '0);
		// Read the last entry, one past it and the far end of the range
		send_command(KIND_GET, 8'd5, '0, '0);
		send_command(KIND_GET, 8'd6, '0, '0);
		send_command(KIND_GET, POS_LAST, POS_LAST, '0);
		// Delete out of range, at the end and at the front
		send_command(KIND_DELETE, POS_LAST, '0, '0);
		send_command(KIND_DELETE, 8'd5, '0, '0);
		send_command(KIND_DELETE, '0, '0, '0);
		// Unknown kinds change nothing
		send_command(KIND_FIRST_UNUSED, POS_LAST, POS_LAST, WORD_ONES);
		send_command(KIND_W'(KIND_FIRST_UNUSED + 1), 8'd1, 8'd2, WORD_MIN);
		send_command(KIND_LAST_UNUSED, '0, '0, WORD_MAX);

		// Random part: fill the store to the top, then drain it, and repeat
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == DRAIN_AT_ITEM) begin
				wait_for_drain();
			end
			// flip direction at full and at empty after lingering a little
			if (growing && fill_level == DEPTH && $urandom_range(5) == 0) begin
				growing = 1'b0;
			end else if (!growing && fill_level == 0 && $urandom_range(3) == 0) begin
				growing = 1'b1;
			end
			roll = $urandom_range(99);
			if (roll < (growing ? 35 : 8)) begin
				op = KIND_APPEND;
			end else if (roll < (growing ? 65 : 16)) begin
				op = KIND_INSERT;
			end else if (roll < (growing ? 77 : 30)) begin
				op = KIND_GET;
			end else if (roll < (growing ? 83 : 75)) begin
				op = KIND_DELETE;
			end else if (roll < 95) begin
				op = KIND_SWAP;
			end else begin
				op = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
			end
			word = ($urandom_range(99) < 15) ? CORNER_WORDS[$urandom_range(4)] : word_t'($urandom);
			send_command(op, pick_position(fill_level), pick_position(fill_level), word);
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("indexed_sequence_store verification clean");
		end else begin
			$display("indexed_sequence_store verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/isst_pkg.sv
rtl/isst_if.sv
rtl/isst_cell.sv
rtl/isst_rdtree.sv
rtl/indexed_sequence_store.sv
tb/sv/isst_result_check.sv
tb/sv/indexed_sequence_store_tb.sv
